// File: sv/radix_sum_converter_macros.svh
// Assertion macros for the radix sum converter.
`ifndef RADIX_SUM_CONVERTER_MACROS_SVH
`define RADIX_SUM_CONVERTER_MACROS_SVH

// Same-cycle implication, reset-gated.
`define RSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-gated.
`define RSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rsc_pkg.sv
// Shared types, constants and helper functions of the radix sum converter.
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned MAX_DIGITS_DEF  = 64;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_A    = 8'h61;
  localparam logic [7:0] TEN       = 8'd10;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  typedef enum logic [1:0] {
    KIND_DIGIT   = 2'd0,
    KIND_END     = 2'd1,
    KIND_CONVERT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ACCUM  = 2'd1,
    ST_DIVIDE = 2'd2,
    ST_EMIT   = 2'd3
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] digit_char;
    logic [4:0] radix;
  } rsc_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } rsc_out_t;

  // Command to the bit-serial accumulator unit.
  typedef struct packed {
    logic       start;
    logic       op_add;  // 1: sum += acc, acc = 0; 0: acc = acc * radix + cval
    logic [4:0] radix;
    logic [8:0] cval;    // digit value, two's complement, sign-extended to full width
  } acc_cmd_t;

  // Digit store write request.
  typedef struct packed {
    logic       we;
    logic [3:0] digit;
  } dig_wr_t;

  // Digit value as a 9-bit signed number; non-digits give c - 'a' + 10.
  function automatic logic [8:0] char_value(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return {1'b0, c - CHAR_ZERO};
    end
    return ({1'b0, c} - {1'b0, CHAR_A}) + {1'b0, TEN};
  endfunction

  function automatic logic [7:0] digit_char_of(input logic [3:0] d);
    if ({4'd0, d} < TEN) begin
      return CHAR_ZERO + {4'd0, d};
    end
    return CHAR_A + {4'd0, d} - TEN;
  endfunction

  function automatic logic [4:0] sat_radix(input logic [4:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

endpackage

// File: sv/rsc_stream_if.sv
// Valid/ready stream interface carrying one request payload.
`timescale 1ns / 1ps

interface rsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/rsc_accum.sv
// Bit-serial accumulator and running sum with multiply-add and add passes.
`timescale 1ns / 1ps

module rsc_accum #(
  parameter int unsigned VALUE_WIDTH = rsc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rsc_pkg::acc_cmd_t      cmd_i,
  input  logic                   sum_clear_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] sum_o
);
  import rsc_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_WIDTH);
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] acc_q, sum_q;
  logic [CW-1:0]          cnt_q;
  logic                   busy_q, add_q;
  logic [4:0]             radix_q;
  logic [8:0]             cval_q;
  logic [5:0]             carry_q;   // multiply-add carry never exceeds 32
  logic [6:0]             mac_sum;
  logic [1:0]             add_sum;

  always_comb begin
    mac_sum = (acc_q[0] ? {2'b00, radix_q} : 7'd0) + {6'd0, cval_q[0]} + {1'b0, carry_q};
    add_sum = {1'b0, sum_q[0]} + {1'b0, acc_q[0]} + {1'b0, carry_q[0]};
  end

  // LSB first; result bits enter at the top, so once the pass has shifted
  // through every bit the register holds the new value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      add_q   <= 1'b0;
      radix_q <= '0;
      cval_q  <= '0;
      carry_q <= '0;
    end else if (cmd_i.start) begin
      busy_q  <= 1'b1;
      cnt_q   <= '0;
      carry_q <= '0;
      add_q   <= cmd_i.op_add;
      radix_q <= cmd_i.radix;
      cval_q  <= cmd_i.cval;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 1'b1;
      cval_q <= {cval_q[8], cval_q[8:1]};
      if (add_q) begin
        sum_q   <= {add_sum[0], sum_q[VALUE_WIDTH-1:1]};
        acc_q   <= {1'b0, acc_q[VALUE_WIDTH-1:1]};
        carry_q <= {5'd0, add_sum[1]};
      end else begin
        acc_q   <= {mac_sum[0], acc_q[VALUE_WIDTH-1:1]};
        carry_q <= mac_sum[6:1];
      end
      if (cnt_q == LAST_BIT) begin
        busy_q <= 1'b0;
      end
    end else if (sum_clear_i) begin
      sum_q <= '0;
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == LAST_BIT);
  assign sum_o  = sum_q;

endmodule

// File: sv/rsc_divider.sv
// Bit-serial restoring divider that peels off output digits, least significant first.
`timescale 1ns / 1ps

module rsc_divider #(
  parameter int unsigned VALUE_WIDTH = rsc_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = rsc_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [4:0]                        radix_i,
  input  logic [VALUE_WIDTH-1:0]            value_i,
  output rsc_pkg::dig_wr_t                  wr_o,
  output logic [$clog2(MAX_DIGITS)-1:0]     wr_addr_o,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [$clog2(MAX_DIGITS+1)-1:0]   count_o
);
  import rsc_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_WIDTH);
  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned NW = $clog2(MAX_DIGITS + 1);
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_WIDTH - 1);
  localparam logic [NW-1:0] DIGIT_LIMIT = NW'(MAX_DIGITS);

  logic [VALUE_WIDTH-1:0] val_q;
  logic [3:0]             rem_q;
  logic [4:0]             radix_q;
  logic [CW-1:0]          cnt_q;
  logic [NW-1:0]          n_q;
  logic                   busy_q, nz_q;

  logic [4:0]    trial, rem_n;
  logic          ge, q_nz, last_bit, fin;
  logic [NW-1:0] n_inc;

  always_comb begin
    trial    = {rem_q, val_q[VALUE_WIDTH-1]};
    ge       = (trial >= radix_q);
    rem_n    = ge ? (trial - radix_q) : trial;
    q_nz     = nz_q | ge;
    n_inc    = n_q + 1'b1;
    last_bit = (cnt_q == LAST_BIT);
    // stop once the quotient is zero or the digit limit is reached
    fin      = busy_q && last_bit && (!q_nz || (n_inc == DIGIT_LIMIT));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q   <= '0;
      rem_q   <= '0;
      radix_q <= RADIX_MIN;
      cnt_q   <= '0;
      n_q     <= '0;
      busy_q  <= 1'b0;
      nz_q    <= 1'b0;
    end else if (start_i) begin
      val_q   <= value_i;
      rem_q   <= '0;
      radix_q <= sat_radix(radix_i);
      cnt_q   <= '0;
      n_q     <= '0;
      busy_q  <= 1'b1;
      nz_q    <= 1'b0;
    end else if (busy_q) begin
      val_q <= {val_q[VALUE_WIDTH-2:0], ge};
      if (last_bit) begin
        cnt_q <= '0;
        n_q   <= n_inc;
        rem_q <= '0;
        nz_q  <= 1'b0;
        if (fin) begin
          busy_q <= 1'b0;
        end
      end else begin
        cnt_q <= cnt_q + 1'b1;
        rem_q <= rem_n[3:0];
        nz_q  <= q_nz;
      end
    end
  end

  assign wr_o.we    = busy_q && last_bit;
  assign wr_o.digit = rem_n[3:0];
  assign wr_addr_o  = n_q[AW-1:0];
  assign busy_o     = busy_q;
  assign done_o     = fin;
  assign count_o    = n_inc;

endmodule

// File: sv/rsc_emitter.sv
// Digit store and reverse-order readout into the registered output channel.
`timescale 1ns / 1ps

module rsc_emitter #(
  parameter int unsigned MAX_DIGITS = rsc_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rsc_pkg::dig_wr_t                wr_i,
  input  logic [$clog2(MAX_DIGITS)-1:0]   wr_addr_i,
  input  logic                            start_i,
  input  logic [$clog2(MAX_DIGITS+1)-1:0] count_i,
  output logic                            done_o,
  rsc_stream_if.source                    out_o
);
  import rsc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned NW = $clog2(MAX_DIGITS + 1);

  logic [3:0]    digit_store_q [MAX_DIGITS];
  logic [3:0]    rdata_q;
  logic [NW-1:0] ptr_q, ptr_m1;
  logic          active_q, data_v_q, data_last_q, out_valid_q;
  rsc_out_t      out_q;
  logic          out_free, move, issue;

  always_comb begin
    ptr_m1   = ptr_q - 1'b1;
    out_free = !out_valid_q || out_o.ready;
    move     = data_v_q && out_free;
    issue    = active_q && (!data_v_q || move);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      digit_store_q[wr_addr_i] <= wr_i.digit;
    end
    if (issue) begin
      rdata_q <= digit_store_q[ptr_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      active_q    <= 1'b0;
      data_v_q    <= 1'b0;
      data_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (start_i) begin
        active_q <= 1'b1;
        ptr_q    <= count_i;
      end else if (issue) begin
        ptr_q <= ptr_m1;
        if (ptr_m1 == '0) begin
          active_q <= 1'b0;
        end
      end

      if (issue) begin
        data_v_q    <= 1'b1;
        data_last_q <= (ptr_m1 == '0);
      end else if (move) begin
        data_v_q <= 1'b0;
      end

      if (move) begin
        out_valid_q    <= 1'b1;
        out_q.out_char <= digit_char_of(rdata_q);
        out_q.last     <= data_last_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign done_o        = move && data_last_q;

endmodule

// File: sv/radix_sum_converter.sv
// Top level of the radix sum converter: request sequencing and unit wiring.
// Digit and end-of-operand requests each run one bit-serial pass (multiply-add or add).
// Convert request: the bit-serial divider produces all output digits, then the emitter
//   sends them one per cycle while the sink is ready; the next request is taken once
//   the last digit has entered the output register. Kind 3 is taken and ignored.
// Reset (rst_ni low, asynchronous) clears accumulator, sum and control; digit store kept.
`timescale 1ns / 1ps

module radix_sum_converter #(
  parameter int unsigned VALUE_WIDTH = rsc_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = rsc_pkg::MAX_DIGITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rsc_stream_if.sink   in_i,
  rsc_stream_if.source out_o
);
  import rsc_pkg::*;
  `include "radix_sum_converter_macros.svh"

  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned NW = $clog2(MAX_DIGITS + 1);

  // Sequencer state
  state_e   state_q, state_d;
  kind_e    in_kind;

  // Accumulator unit
  acc_cmd_t               acc_cmd;
  logic                   sum_clear;
  logic                   acc_busy, acc_done;
  logic [VALUE_WIDTH-1:0] sum;

  // Divider unit
  logic          div_start, div_busy, div_done;
  dig_wr_t       dig_wr;
  logic [AW-1:0] dig_addr;
  logic [NW-1:0] div_count;

  // Emitter
  logic emit_done;

  assign in_kind  = kind_e'(in_i.payload.kind);
  // Only one request is in work at a time; the output register lets the
  // next one start while the final digit still waits at the sink.
  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    acc_cmd       = '0;
    acc_cmd.radix = in_i.payload.radix;          // digit radix used as given
    acc_cmd.cval  = char_value(in_i.payload.digit_char);
    sum_clear     = 1'b0;
    div_start     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          unique case (in_kind)
            KIND_DIGIT: begin
              acc_cmd.start = 1'b1;
              state_d       = ST_ACCUM;
            end
            KIND_END: begin
              acc_cmd.start  = 1'b1;
              acc_cmd.op_add = 1'b1;
              state_d        = ST_ACCUM;
            end
            KIND_CONVERT: begin
              // divider takes the sum at this edge, the sum clears at the same edge
              div_start = 1'b1;
              sum_clear = 1'b1;
              state_d   = ST_DIVIDE;
            end
            KIND_NONE: ;  // ignored, no state change
            default: ;
          endcase
        end
      end
      ST_ACCUM: begin
        if (acc_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  rsc_accum #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (acc_cmd),
    .sum_clear_i(sum_clear),
    .busy_o     (acc_busy),
    .done_o     (acc_done),
    .sum_o      (sum)
  );

  // Saturates the output radix to 2..16; a zero sum yields one '0' digit
  // because the first division always stores a digit.
  rsc_divider #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .radix_i  (in_i.payload.radix),
    .value_i  (sum),
    .wr_o     (dig_wr),
    .wr_addr_o(dig_addr),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .count_o  (div_count)
  );

  // Reads the stored digits back most significant first.
  rsc_emitter #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (dig_wr),
    .wr_addr_i(dig_addr),
    .start_i  (div_done),
    .count_i  (div_count),
    .done_o   (emit_done),
    .out_o    (out_o)
  );

  // The two serial units never run at once.
  `RSC_ASSERT_IMPL(a_units_exclusive, 1'b1, !(acc_busy && div_busy), "accum and divider both busy")
  // A result only appears out of the emit phase.
  `RSC_ASSERT_IMPL(a_out_from_emit, $rose(out_o.valid), $past(state_q) == ST_EMIT, "output outside emit")
  // Each convert ends with between one and MAX_DIGITS digits.
  `RSC_ASSERT_IMPL(a_digit_count, div_done, (div_count != '0) && (div_count <= NW'(MAX_DIGITS)), "bad digit count")

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the radix sum converter: queue-fed driver, predictor and monitor.
`timescale 1ns / 1ps

module testbench;
  import rsc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned HOLD_CYCLES  = 2000;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned LIMIT_CYCLES = 8_000_000;
  localparam int unsigned DIGIT_LIMIT  = 64;

  typedef enum logic [1:0] {
    IDLE_NONE     = 2'd0,
    IDLE_SENDER   = 2'd1,
    IDLE_RECEIVER = 2'd2,
    IDLE_BOTH     = 2'd3
  } idle_mode_e;

  typedef struct {
    rsc_in_t    req;
    idle_mode_e mode;
    bit         drain;  // wait until all digits are out before offering
    bit         hold;   // start a long receiver hold-off when offered
  } pend_t;

  logic clk_i;
  logic rst_ni;

  rsc_stream_if #(.payload_t(rsc_in_t))  req_if ();
  rsc_stream_if #(.payload_t(rsc_out_t)) dig_if ();

  radix_sum_converter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (dig_if)
  );

  pend_t      pending[$];
  rsc_out_t   digits_due[$];
  pend_t      next_req;
  rsc_out_t   exp_d;
  idle_mode_e cur_mode = IDLE_NONE;

  logic [63:0] acc_model = '0;
  logic [63:0] sum_model = '0;

  logic        req_taken   = 1'b0;
  int unsigned hold_serial = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned total_reqs  = 0;
  int unsigned accepted    = 0;
  int unsigned converts    = 0;
  int unsigned checked     = 0;
  int unsigned errors      = 0;
  int unsigned stim_cnt    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] ascii_of_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'd0, d};
    end
    return CHAR_A + {4'd0, d} - TEN;
  endfunction

  function automatic int unsigned sender_idle_pct(input idle_mode_e m);
    case (m)
      IDLE_SENDER: return 87;
      IDLE_BOTH:   return 8;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct(input idle_mode_e m);
    case (m)
      IDLE_RECEIVER: return 87;
      IDLE_BOTH:     return 8;
      default:       return 0;
    endcase
  endfunction

  // Updates the accumulator/sum copy and queues the digits a request emits.
  task automatic predict_request(input rsc_in_t r);
    logic [63:0] cval;
    logic [63:0] v;
    logic [63:0] base;
    logic [3:0]  lsd_first[$];
    int          n;
    case (kind_e'(r.kind))
      KIND_DIGIT: begin
        if (r.digit_char >= CHAR_ZERO && r.digit_char <= CHAR_NINE) begin
          cval = {56'd0, r.digit_char - CHAR_ZERO};
        end else begin
          // non-digits wrap modulo 2^64
          cval = {56'd0, r.digit_char} - {56'd0, CHAR_A} + {56'd0, TEN};
        end
        acc_model = acc_model * {59'd0, r.radix} + cval;
      end
      KIND_END: begin
        sum_model = sum_model + acc_model;
        acc_model = '0;
      end
      KIND_CONVERT: begin
        if (r.radix < RADIX_MIN) begin
          base = {59'd0, RADIX_MIN};
        end else if (r.radix > RADIX_MAX) begin
          base = {59'd0, RADIX_MAX};
        end else begin
          base = {59'd0, r.radix};
        end
        v = sum_model;
        if (v == '0) begin
          lsd_first.push_back(4'd0);
        end else begin
          while (v != '0 && lsd_first.size() < DIGIT_LIMIT) begin
            lsd_first.push_back(4'(v % base));
            v = v / base;
          end
        end
        n = lsd_first.size();
        for (int k = n - 1; k >= 0; k--) begin
          digits_due.push_back('{out_char: ascii_of_digit(lsd_first[k]), last: (k == 0)});
        end
        sum_model = '0;
        converts++;
      end
      default: ;  // kind 3 does nothing
    endcase
  endtask

  task automatic queue_request(input kind_e k, input logic [7:0] c, input logic [4:0] r,
                               input idle_mode_e m, input bit drain, input bit hold);
    pend_t p;
    p.req   = '{kind: k, digit_char: c, radix: r};
    p.mode  = m;
    p.drain = drain;
    p.hold  = hold;
    pending.push_back(p);
    if (k != KIND_NONE) begin
      stim_cnt++;
    end
  endtask

  // Driver: new request or idle at the falling edge, valid held until taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        if (pending.size() == 0 || (pending[0].drain && digits_due.size() != 0) ||
            $urandom_range(0, 99) < sender_idle_pct(cur_mode)) begin
          req_if.valid <= 1'b0;
        end else begin
          next_req = pending.pop_front();
          req_if.valid   <= 1'b1;
          req_if.payload <= next_req.req;
          cur_mode       <= next_req.mode;
          if (next_req.hold) begin
            hold_serial <= hold_serial + 1;
          end
        end
      end
    end
  end

  // Receiver ready: random stalls per phase, plus a counted long hold-off.
  always @(negedge clk_i) begin
    if (hold_seen != hold_serial) begin
      hold_seen    <= hold_serial;
      hold_left    <= HOLD_CYCLES;
      dig_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      dig_if.ready <= 1'b0;
    end else begin
      dig_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct(cur_mode));
    end
  end

  // Monitor: predict on accepted requests, check accepted digits.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        predict_request(req_if.payload);
        accepted++;
      end
      if (dig_if.valid && dig_if.ready) begin
        if (digits_due.size() == 0) begin
          $error("unexpected digit: out_char %h last %b",
                 dig_if.payload.out_char, dig_if.payload.last);
          errors++;
        end else begin
          exp_d = digits_due.pop_front();
          checked++;
          if (dig_if.payload.out_char !== exp_d.out_char) begin
            $error("out_char: expected %h, actual %h", exp_d.out_char, dig_if.payload.out_char);
            errors++;
          end
          if (dig_if.payload.last !== exp_d.last) begin
            $error("last: expected %b, actual %b", exp_d.last, dig_if.payload.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d digits outstanding", cycle_cnt, digits_due.size());
      $display("FAIL radix_sum_converter");
      $finish;
    end
  end

  initial begin
    idle_mode_e  mode;
    int unsigned phase;
    int unsigned last_phase;
    int unsigned pick;
    int unsigned ndig;
    logic [4:0]  r;
    bit          drain;
    bit          hold;
    bit          hold_done;

    req_if.valid   = 1'b0;
    req_if.payload = '0;
    dig_if.ready   = 1'b0;
    rst_ni         = 1'b0;

    // Directed: zero sum, extremes of fields and radices, ignored kind.
    queue_request(KIND_CONVERT, 8'h00, 5'd10, IDLE_NONE, 0, 0);  // zero sum gives '0'
    queue_request(KIND_DIGIT,   "f",   5'd16, IDLE_NONE, 0, 0);
    queue_request(KIND_DIGIT,   "f",   5'd16, IDLE_NONE, 0, 0);
    queue_request(KIND_END,     8'h00, 5'd0,  IDLE_NONE, 0, 0);
    queue_request(KIND_CONVERT, 8'hff, 5'd2,  IDLE_NONE, 0, 1);  // eight digits, long hold
    queue_request(KIND_DIGIT,   "9",   5'd10, IDLE_NONE, 0, 0);
    queue_request(KIND_DIGIT,   "0",   5'd10, IDLE_NONE, 0, 0);
    queue_request(KIND_DIGIT,   "z",   5'd10, IDLE_NONE, 0, 0);  // letter past 'f'
    queue_request(KIND_END,     8'hff, 5'd31, IDLE_NONE, 0, 0);
    queue_request(KIND_DIGIT,   "a",   5'd16, IDLE_NONE, 0, 0);
    queue_request(KIND_END,     8'h00, 5'd16, IDLE_NONE, 0, 0);
    queue_request(KIND_CONVERT, 8'h00, 5'd31, IDLE_NONE, 0, 0);  // saturates to 16
    queue_request(KIND_DIGIT,   8'h00, 5'd0,  IDLE_NONE, 0, 0);  // wraps, zero radix
    queue_request(KIND_DIGIT,   8'hff, 5'd31, IDLE_NONE, 0, 0);  // top radix field
    queue_request(KIND_END,     8'h00, 5'd2,  IDLE_NONE, 0, 0);
    queue_request(KIND_NONE,    8'hff, 5'd31, IDLE_NONE, 0, 0);  // ignored
    queue_request(KIND_CONVERT, 8'h00, 5'd0,  IDLE_NONE, 0, 0);  // saturates to 2
    queue_request(KIND_DIGIT,   "7",   5'd8,  IDLE_NONE, 0, 0);
    queue_request(KIND_END,     8'h00, 5'd8,  IDLE_NONE, 0, 0);
    queue_request(KIND_DIGIT,   "5",   5'd6,  IDLE_NONE, 0, 0);
    queue_request(KIND_END,     8'h00, 5'd6,  IDLE_NONE, 0, 0);
    queue_request(KIND_CONVERT, 8'h00, 5'd1,  IDLE_NONE, 0, 0);
    queue_request(KIND_CONVERT, 8'h00, 5'd17, IDLE_NONE, 0, 0);  // zero sum again

    // Random: mostly well-formed operands, four idle phases, some noise.
    stim_cnt   = 0;
    last_phase = 0;
    hold_done  = 0;
    while (stim_cnt < RANDOM_ITEMS) begin
      phase = (stim_cnt * 4) / RANDOM_ITEMS;
      mode  = idle_mode_e'(phase);
      drain = (phase != last_phase) || (stim_cnt == 0);
      last_phase = phase;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        r    = 5'($urandom_range(2, 16));
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        for (int k = 0; k < ndig; k++) begin
          queue_request(KIND_DIGIT, ascii_of_digit(4'($urandom_range(0, r - 1))), r,
                        mode, drain, 0);
          drain = 0;
        end
        queue_request(KIND_END, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                      mode, 0, 0);
        hold = !hold_done && stim_cnt > 20;
        if (hold || $urandom_range(0, 3) == 0) begin
          queue_request(KIND_CONVERT, 8'($urandom_range(0, 255)), 5'($urandom_range(2, 16)),
                        mode, 0, hold);
          if (hold) begin
            hold_done = 1;
          end
        end
      end else begin
        queue_request(kind_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      5'($urandom_range(0, 31)), mode, drain, 0);
      end
    end
    queue_request(KIND_CONVERT, 8'h00, 5'($urandom_range(0, 31)), IDLE_BOTH, 1, 0);
    total_reqs = pending.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted < total_reqs || digits_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d requests and %0d converts, %0d digits checked, %0d cycles",
             accepted, converts, checked, cycle_cnt);
    $display("phases: no idling, sender gaps, receiver stalls, both, one long hold-off");
    if (errors == 0 && digits_due.size() == 0) begin
      $display("PASS radix_sum_converter");
    end else begin
      $display("FAIL radix_sum_converter");
    end
    $finish;
  end

endmodule
